// File: src/egc_pkg.sv
// ----------------------------------------------------------------------------
// egc_pkg
// Shared types, constants and a helper function of the Elias gamma bit codec.
// ----------------------------------------------------------------------------
package egc_pkg;

    localparam int VALUE_BITS = 32;
    localparam logic [31:0] VALUE_MASK = 32'((64'd1 << VALUE_BITS) - 64'd1);
    localparam logic [5:0]  END_RUN    = 6'd16;
    localparam logic [31:0] END_VALUE  = 32'h0001_0000;
    localparam logic [5:0]  END_LENGTH = 6'd33;
    localparam logic [5:0]  RUN_LIMIT  = 6'(VALUE_BITS);

    typedef enum logic [1:0] {
        KIND_BIT   = 2'd0,
        KIND_VALUE = 2'd1,
        KIND_END   = 2'd2,
        KIND_ERROR = 2'd3
    } kind_t;

    typedef enum logic {
        OP_ENCODE = 1'b0,
        OP_SINGLE = 1'b1
    } op_t;

    typedef struct packed {
        op_t         op;
        kind_t       kind;
        logic [31:0] data;
        logic [5:0]  code_length;
        logic [4:0]  msb;
    } cmd_t;

    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } queue_head_t;

    // Index of the highest set bit, found by halving the search window.
    function automatic logic [4:0] msb_index(input logic [31:0] v);
        logic [31:0] x;
        logic [4:0]  pos;
        x   = v;
        pos = 5'd0;
        if (x[31:16] != 16'd0)
        begin
            pos[4] = 1'b1;
            x      = x >> 16;
        end
        if (x[15:8] != 8'd0)
        begin
            pos[3] = 1'b1;
            x      = x >> 8;
        end
        if (x[7:4] != 4'd0)
        begin
            pos[2] = 1'b1;
            x      = x >> 4;
        end
        if (x[3:2] != 2'd0)
        begin
            pos[1] = 1'b1;
            x      = x >> 2;
        end
        if (x[1])
        begin
            pos[0] = 1'b1;
        end
        return pos;
    endfunction

endpackage

// File: src/egc_front.sv
// ----------------------------------------------------------------------------
// egc_front
// Accepts input transactions, runs the decoder state and turns each item into
// a command for the emitter, or into nothing for a quiet decode bit.
// ----------------------------------------------------------------------------
module egc_front
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          accept,
    input  logic          func,
    input  logic [31:0]   value,
    input  logic          in_bit,
    output logic          push,
    output egc_pkg::cmd_t push_cmd
);
    import egc_pkg::*;

    logic        reading_bits_reg, reading_bits_next;
    logic [5:0]  zero_run_reg, zero_run_next;
    logic [4:0]  bits_left_reg, bits_left_next;
    logic [31:0] accumulator_reg, accumulator_next;

    logic [31:0] enc_value;
    logic [4:0]  enc_msb;
    logic [31:0] acc_shift;
    logic [4:0]  bits_dec;
    logic [5:0]  run_inc;

    assign enc_value = value & VALUE_MASK;
    assign enc_msb   = msb_index(enc_value);
    assign acc_shift = {accumulator_reg[30:0], in_bit};
    assign bits_dec  = bits_left_reg - 5'd1;
    assign run_inc   = zero_run_reg + 6'd1;

    always_comb
    begin
        reading_bits_next = reading_bits_reg;
        zero_run_next     = zero_run_reg;
        bits_left_next    = bits_left_reg;
        accumulator_next  = accumulator_reg;
        push              = 1'b0;
        push_cmd.op          = OP_SINGLE;
        push_cmd.kind        = KIND_ERROR;
        push_cmd.data        = 32'd0;
        push_cmd.code_length = 6'd0;
        push_cmd.msb         = 5'd0;

        if (accept)
        begin
            if (!func)
            begin
                push = 1'b1;
                if (enc_value != 32'd0)
                begin
                    push_cmd.op          = OP_ENCODE;
                    push_cmd.kind        = KIND_BIT;
                    push_cmd.data        = enc_value;
                    push_cmd.code_length = {enc_msb, 1'b1};
                    push_cmd.msb         = enc_msb;
                end
            end
            else if (reading_bits_reg)
            begin
                accumulator_next = acc_shift;
                bits_left_next   = bits_dec;
                if (bits_dec == 5'd0)
                begin
                    push                 = 1'b1;
                    push_cmd.kind        = KIND_VALUE;
                    push_cmd.data        = acc_shift;
                    push_cmd.code_length = {zero_run_reg[4:0], 1'b1};
                    reading_bits_next    = 1'b0;
                    zero_run_next        = 6'd0;
                    bits_left_next       = 5'd0;
                    accumulator_next     = 32'd0;
                end
            end
            else if (!in_bit)
            begin
                zero_run_next = run_inc;
                if (run_inc >= RUN_LIMIT)
                begin
                    push          = 1'b1;
                    zero_run_next = 6'd0;
                end
            end
            else if (zero_run_reg == END_RUN)
            begin
                push                 = 1'b1;
                push_cmd.kind        = KIND_END;
                push_cmd.data        = END_VALUE;
                push_cmd.code_length = END_LENGTH;
                zero_run_next        = 6'd0;
            end
            else if (zero_run_reg == 6'd0)
            begin
                push                 = 1'b1;
                push_cmd.kind        = KIND_VALUE;
                push_cmd.data        = 32'd1;
                push_cmd.code_length = 6'd1;
            end
            else
            begin
                reading_bits_next = 1'b1;
                bits_left_next    = zero_run_reg[4:0];
                accumulator_next  = 32'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reading_bits_reg <= 1'b0;
            zero_run_reg     <= 6'd0;
            bits_left_reg    <= 5'd0;
            accumulator_reg  <= 32'd0;
        end
        else
        begin
            reading_bits_reg <= reading_bits_next;
            zero_run_reg     <= zero_run_next;
            bits_left_reg    <= bits_left_next;
            accumulator_reg  <= accumulator_next;
        end
    end

endmodule

// File: src/egc_queue.sv
// ----------------------------------------------------------------------------
// egc_queue
// Two-entry command queue between the classifier and the emitter.
// ----------------------------------------------------------------------------
module egc_queue
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  egc_pkg::cmd_t        push_cmd,
    input  logic                 pop,
    output logic                 full,
    output egc_pkg::queue_head_t head
);
    import egc_pkg::*;

    cmd_t       slots_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign full       = (count_reg == 2'd2);
    assign head.valid = (count_reg != 2'd0);
    assign head.cmd   = slots_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// File: src/egc_back.sv
// ----------------------------------------------------------------------------
// egc_back
// Emitter: walks each encode command one code bit per cycle unless the output
// stalls, and passes single results through, into a registered output stage.
// ----------------------------------------------------------------------------
module egc_back
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  egc_pkg::queue_head_t head,
    output logic                 pop,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [39:0]          m_tdata,
    output logic [1:0]           m_tuser,
    output logic                 m_tlast
);
    import egc_pkg::*;

    cmd_t        cur_reg;
    logic        cur_valid_reg, cur_valid_next;
    logic [5:0]  idx_reg, idx_next;

    logic        out_valid_reg, out_valid_next;
    kind_t       out_kind_reg;
    logic        out_bit_reg;
    logic [31:0] out_decoded_reg;
    logic [5:0]  out_length_reg;
    logic        out_last_reg;

    logic        load_out;
    logic        advance;
    logic [5:0]  last_idx;
    logic [5:0]  bit_sel;
    logic        res_bit;
    logic        res_last;
    logic [31:0] res_decoded;

    assign load_out = !out_valid_reg || m_tready;
    assign advance  = cur_valid_reg && load_out;
    assign last_idx = {cur_reg.msb, 1'b0};
    assign bit_sel  = last_idx - idx_reg;

    always_comb
    begin
        res_bit     = 1'b0;
        res_last    = 1'b1;
        res_decoded = cur_reg.data;
        if (cur_reg.op == OP_ENCODE)
        begin
            res_decoded = 32'd0;
            res_last    = (idx_reg == last_idx);
            if (idx_reg >= {1'b0, cur_reg.msb})
            begin
                res_bit = cur_reg.data[bit_sel[4:0]];
            end
        end
    end

    assign pop = head.valid && (!cur_valid_reg || (advance && res_last));

    always_comb
    begin
        cur_valid_next = cur_valid_reg;
        idx_next       = idx_reg;
        if (advance)
        begin
            idx_next = idx_reg + 6'd1;
            if (res_last)
            begin
                cur_valid_next = 1'b0;
            end
        end
        if (pop)
        begin
            cur_valid_next = 1'b1;
            idx_next       = 6'd0;
        end
        out_valid_next = out_valid_reg;
        if (load_out)
        begin
            out_valid_next = cur_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            idx_reg       <= 6'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cur_valid_reg <= cur_valid_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cur_reg <= head.cmd;
        end
        if (advance)
        begin
            out_kind_reg    <= cur_reg.kind;
            out_bit_reg     <= res_bit;
            out_decoded_reg <= res_decoded;
            out_length_reg  <= cur_reg.code_length;
            out_last_reg    <= res_last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_length_reg, out_decoded_reg, out_bit_reg};
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;

endmodule

// File: src/elias_gamma_bit_codec_core.sv
// ----------------------------------------------------------------------------
// elias_gamma_bit_codec_core
// Bit-serial Elias gamma encoder and decoder on streaming interfaces.
// ----------------------------------------------------------------------------
// Each input transaction either encodes a positive value or feeds one stream
// bit to the decoder. A decode bit is accepted every cycle the queue is not full
// and yields at most one result. An encode item whose highest set bit is
// n produces 2n+1 result transactions, one per cycle while not stalled, from
// the single emitter; encoding zero yields one error result. A two-entry command
// queue sits between the classifier and the emitter, so input is taken while
// earlier codes are still being sent and stalls only when that queue is full.
module elias_gamma_bit_codec_core
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // value[31:0], in_bit[32], zero padding
    input  logic [0:0]  s_tuser,   // func[0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // out_bit[0], decoded[32:1], code_length[38:33]
    output logic [1:0]  m_tuser,   // kind[1:0]
    output logic        m_tlast
);
    import egc_pkg::*;

    logic        accept;
    logic        push;
    cmd_t        push_cmd;
    logic        pop;
    logic        full;
    queue_head_t head;

    assign s_tready = !full;
    assign accept   = s_tvalid && s_tready;

    egc_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .func     (s_tuser[0]),
        .value    (s_tdata[31:0]),
        .in_bit   (s_tdata[32]),
        .push     (push),
        .push_cmd (push_cmd)
    );

    egc_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .full     (full),
        .head     (head)
    );

    egc_back u_back
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .head     (head),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

// File: tb/sv/elias_gamma_bit_codec_core_tb.sv
// ----------------------------------------------------------------------------
// elias_gamma_bit_codec_core_tb
// Self-checking testbench for the bit-serial Elias gamma encoder and decoder.
// A short directed table covers zero, the widest values, interleaved encode
// and decode traffic, and an over-long zero run. Random encode values and
// well-formed coded streams then follow, mixed with end markers, over-long
// runs and noise bits. Every result transaction is checked field by field
// against a predictor of the codec; both sides stall at random until the final third.
// ----------------------------------------------------------------------------
module elias_gamma_bit_codec_core_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import egc_pkg::*;

    typedef struct packed {
        op_t         op;
        logic [31:0] value;
        logic        in_bit;
    } codec_item_t;

    typedef struct packed {
        kind_t       kind;
        logic        out_bit;
        logic [31:0] decoded;
        logic [5:0]  code_length;
        logic        last;
    } codec_result_t;

    typedef struct packed {
        codec_item_t   item;
        logic [5:0]    reps;
        logic          typed;
        codec_result_t result;
    } directed_row_t;

    localparam int DIRECTED_ROWS = 12;
    localparam int RANDOM_ITEMS  = 365;

    // The typed result, where there is one, belongs to the last repetition of the row.
    directed_row_t directed_rows [DIRECTED_ROWS] = '{
        '{'{OP_ENCODE, 32'h0000_0000, 1'b0}, 6'd1,  1'b1, '{KIND_ERROR, 1'b0, 32'd0, 6'd0, 1'b1}},
        '{'{OP_ENCODE, 32'h0000_0001, 1'b1}, 6'd1,  1'b1, '{KIND_BIT,   1'b1, 32'd0, 6'd1, 1'b1}},
        '{'{OP_ENCODE, 32'hFFFF_FFFF, 1'b0}, 6'd1,  1'b0, '0},
        '{'{OP_ENCODE, 32'h8000_0000, 1'b1}, 6'd1,  1'b0, '0},
        '{'{OP_ENCODE, 32'h0000_0006, 1'b1}, 6'd1,  1'b0, '0},
        '{'{OP_SINGLE, 32'hFFFF_FFFF, 1'b1}, 6'd1,  1'b1, '{KIND_VALUE, 1'b0, 32'd1, 6'd1, 1'b1}},
        '{'{OP_SINGLE, 32'h0000_0000, 1'b0}, 6'd1,  1'b0, '0},
        '{'{OP_SINGLE, 32'h5555_5555, 1'b1}, 6'd1,  1'b0, '0},
        '{'{OP_ENCODE, 32'h0000_0003, 1'b0}, 6'd1,  1'b0, '0},
        '{'{OP_SINGLE, 32'hAAAA_AAAA, 1'b1}, 6'd1,  1'b0, '0},
        '{'{OP_SINGLE, 32'hFFFF_FFFF, 1'b0}, 6'd32, 1'b1, '{KIND_ERROR, 1'b0, 32'd0, 6'd0, 1'b1}},
        '{'{OP_SINGLE, 32'h0000_0000, 1'b1}, 6'd1,  1'b1, '{KIND_VALUE, 1'b0, 32'd1, 6'd1, 1'b1}}
    };

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata  = '0;
    logic [0:0]  s_tuser  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;

    int send_idle_pct = 15;
    int recv_idle_pct = 71;
    int failures      = 0;

    logic          dec_reading;
    logic [5:0]    dec_zero_run;
    logic [4:0]    dec_bits_left;
    logic [31:0]   dec_accumulator;

    codec_result_t step_results [$];
    codec_result_t awaited_results [$];
    codec_item_t   stimulus [$];

    elias_gamma_bit_codec_core i_dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    initial
    begin
        #2ms;
        $display("elias_gamma_bit_codec_core verification failed");
        $finish;
    end

    function automatic int top_bit(input logic [31:0] v);
        int pos;
        pos = 0;
        for (int i = 0; i < 32; i++)
        begin
            if (v[i])
            begin
                pos = i;
            end
        end
        return pos;
    endfunction

    function automatic codec_result_t result_of(input kind_t k, input logic b,
                                                input logic [31:0] d,
                                                input logic [5:0] len,
                                                input logic l);
        codec_result_t r;
        r.kind        = k;
        r.out_bit     = b;
        r.decoded     = d;
        r.code_length = len;
        r.last        = l;
        return r;
    endfunction

    task automatic decoder_clear();
        dec_reading     = 1'b0;
        dec_zero_run    = '0;
        dec_bits_left   = '0;
        dec_accumulator = '0;
    endtask

    // Works out the results of one input transaction and advances the decoder.
    task automatic gamma_predict(input codec_item_t it);
        logic [31:0] v;
        logic [5:0]  len;
        int          msb;
        step_results.delete();
        if (it.op == OP_ENCODE)
        begin
            v = it.value & VALUE_MASK;
            if (v == 32'd0)
            begin
                step_results.push_back(result_of(KIND_ERROR, 1'b0, 32'd0, 6'd0, 1'b1));
            end
            else
            begin
                msb = top_bit(v);
                len = 6'(2 * msb + 1);
                for (int i = 0; i < msb; i++)
                begin
                    step_results.push_back(result_of(KIND_BIT, 1'b0, 32'd0, len, 1'b0));
                end
                for (int i = msb; i >= 0; i--)
                begin
                    step_results.push_back(result_of(KIND_BIT, v[i], 32'd0, len, i == 0));
                end
            end
        end
        else if (dec_reading)
        begin
            dec_accumulator = {dec_accumulator[30:0], it.in_bit};
            dec_bits_left   = dec_bits_left - 5'd1;
            if (dec_bits_left == 5'd0)
            begin
                step_results.push_back(result_of(KIND_VALUE, 1'b0, dec_accumulator,
                                                 6'(2 * dec_zero_run + 1), 1'b1));
                decoder_clear();
            end
        end
        else if (!it.in_bit)
        begin
            dec_zero_run = dec_zero_run + 6'd1;
            if (dec_zero_run >= RUN_LIMIT)
            begin
                step_results.push_back(result_of(KIND_ERROR, 1'b0, 32'd0, 6'd0, 1'b1));
                decoder_clear();
            end
        end
        else if (dec_zero_run == END_RUN)
        begin
            step_results.push_back(result_of(KIND_END, 1'b0, END_VALUE, END_LENGTH, 1'b1));
            decoder_clear();
        end
        else if (dec_zero_run == 6'd0)
        begin
            step_results.push_back(result_of(KIND_VALUE, 1'b0, 32'd1, 6'd1, 1'b1));
            decoder_clear();
        end
        else
        begin
            dec_reading     = 1'b1;
            dec_bits_left   = dec_zero_run[4:0];
            dec_accumulator = 32'd1;
        end
    endtask

    function automatic logic [31:0] gamma_value();
        int          n;
        logic [31:0] low;
        n   = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 31) : $urandom_range(0, 10);
        low = $urandom;
        return (32'd1 << n) | (low & ((32'd1 << n) - 32'd1));
    endfunction

    task automatic add_encode(input logic [31:0] v);
        codec_item_t it;
        it.op     = OP_ENCODE;
        it.value  = v;
        it.in_bit = 1'($urandom_range(0, 1));
        stimulus.push_back(it);
    endtask

    task automatic add_stream_bit(input logic b);
        codec_item_t it;
        if ($urandom_range(0, 19) == 0)
        begin
            add_encode(gamma_value());
        end
        it.op     = OP_SINGLE;
        it.value  = $urandom;
        it.in_bit = b;
        stimulus.push_back(it);
    endtask

    task automatic build_random_stimulus();
        int          sel;
        int          n;
        logic [31:0] v;
        while (stimulus.size() < RANDOM_ITEMS)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 30)
            begin
                add_encode(($urandom_range(0, 15) == 0) ? 32'd0 : gamma_value());
            end
            else if (sel < 85)
            begin
                v = gamma_value();
                n = top_bit(v);
                for (int i = 0; i < n; i++)
                begin
                    add_stream_bit(1'b0);
                end
                for (int i = n; i >= 0; i--)
                begin
                    add_stream_bit(v[i]);
                end
            end
            else if (sel < 91)
            begin
                repeat (16) add_stream_bit(1'b0);
                add_stream_bit(1'b1);
            end
            else if (sel < 95)
            begin
                repeat (VALUE_BITS) add_stream_bit(1'b0);
            end
            else
            begin
                repeat ($urandom_range(1, 6)) add_stream_bit(1'($urandom_range(0, 1)));
            end
        end
    endtask

    // Called at a falling edge; returns at the falling edge after the transaction.
    task automatic send_item(input codec_item_t it);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'd0, it.in_bit, it.value};
        s_tuser  <= it.op;
        @(posedge clk);
        while (!s_tready)
        begin
            @(posedge clk);
        end
        @(negedge clk);
    endtask

    always @(negedge clk)
    begin
        m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        codec_result_t got;
        codec_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = result_of(kind_t'(m_tuser), m_tdata[0], m_tdata[32:1], m_tdata[38:33],
                            m_tlast);
            if (awaited_results.size() == 0)
            begin
                $error("result transaction with none expected: kind %0d", got.kind);
                failures++;
            end
            else
            begin
                want = awaited_results.pop_front();
                if (got.kind !== want.kind)
                begin
                    $error("kind: expected %0d, actual %0d", want.kind, got.kind);
                    failures++;
                end
                if (got.out_bit !== want.out_bit)
                begin
                    $error("out_bit: expected %0d, actual %0d", want.out_bit, got.out_bit);
                    failures++;
                end
                if (got.decoded !== want.decoded)
                begin
                    $error("decoded: expected %h, actual %h", want.decoded, got.decoded);
                    failures++;
                end
                if (got.code_length !== want.code_length)
                begin
                    $error("code_length: expected %0d, actual %0d", want.code_length,
                           got.code_length);
                    failures++;
                end
                if (got.last !== want.last)
                begin
                    $error("last: expected %0d, actual %0d", want.last, got.last);
                    failures++;
                end
            end
        end
    end

    initial
    begin
        decoder_clear();
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed_rows[r])
        begin
            for (int rep = 1; rep <= directed_rows[r].reps; rep++)
            begin
                gamma_predict(directed_rows[r].item);
                if (directed_rows[r].typed && rep == directed_rows[r].reps)
                begin
                    awaited_results.push_back(directed_rows[r].result);
                end
                else
                begin
                    foreach (step_results[k])
                    begin
                        awaited_results.push_back(step_results[k]);
                    end
                end
                send_item(directed_rows[r].item);
            end
        end

        build_random_stimulus();
        foreach (stimulus[idx])
        begin
            if (idx >= 2 * stimulus.size() / 3)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            else if (idx >= stimulus.size() / 3)
            begin
                send_idle_pct = 71;
                recv_idle_pct = 15;
            end
            gamma_predict(stimulus[idx]);
            foreach (step_results[k])
            begin
                awaited_results.push_back(step_results[k]);
            end
            send_item(stimulus[idx]);
        end
        s_tvalid <= 1'b0;

        while (awaited_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (32) @(posedge clk);
        if (failures == 0)
        begin
            $display("elias_gamma_bit_codec_core verification clean");
        end
        else
        begin
            $display("elias_gamma_bit_codec_core verification failed");
        end
        $finish;
    end

endmodule
